// File: hw/rtl/clf_pkg.sv
`timescale 1ns / 1ps

package clf_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned CW     = 48;
    localparam int unsigned DW     = 32;
    localparam int unsigned AW     = 84;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_FLL   = 2'd1;
    localparam logic [1:0] KIND_PLL   = 2'd2;

    localparam logic [2:0] CFG_FLL_LAG2 = 3'd0;
    localparam logic [2:0] CFG_FLL_LAG1 = 3'd1;
    localparam logic [2:0] CFG_FLL_NOW  = 3'd2;
    localparam logic [2:0] CFG_PLL_LAG1 = 3'd3;
    localparam logic [2:0] CFG_PLL_NOW  = 3'd4;

    localparam logic signed [CW-1:0] RST_FLL_LAG2 = 48'sd204280464348;
    localparam logic signed [CW-1:0] RST_FLL_LAG1 = -48'sd408758805604;
    localparam logic signed [CW-1:0] RST_FLL_NOW  = 48'sd204478405179;
    localparam logic signed [CW-1:0] RST_PLL_LAG1 = -48'sd30821509949817;
    localparam logic signed [CW-1:0] RST_PLL_NOW  = 48'sd31262018288369;

    typedef enum logic [1:0] {
        OP_START,
        OP_FLL,
        OP_PLL
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic signed [DW-1:0]   value;
    } t_item;

    typedef struct packed {
        logic signed [CW-1:0] fll_lag2;
        logic signed [CW-1:0] fll_lag1;
        logic signed [CW-1:0] fll_now;
        logic signed [CW-1:0] pll_lag1;
        logic signed [CW-1:0] pll_now;
    } t_coefs;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_FIN
    } t_state;

endpackage

// File: hw/rtl/carrier_loop_filter.sv
`timescale 1ns / 1ps
// Throughput: one start item per cycle while the tap sequencer is idle. FLL and PLL items
// are filtered one at a time on the shared 24x32 multiplier pair, one filter tap per cycle.
// A four-entry input queue keeps taking items while the tap sequencer works.
// Reset (synchronous, active low) empties the input queue and the result slot, loads the default weights and
// clears all filter history.

module carrier_loop_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_kind,
    input  logic signed [clf_pkg::DW-1:0] i_sample_value,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [clf_pkg::DW-1:0] o_carrier_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [clf_pkg::CW-1:0]        i_cfg_data
);

    clf_pkg::t_head   w_head;
    logic             w_head_pop;
    clf_pkg::t_coefs  r_coefs;
    logic             w_res_valid;
    logic signed [clf_pkg::DW-1:0] w_res_value;
    logic             w_slot_ready;
    logic             r_ov;
    logic signed [clf_pkg::DW-1:0] r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.fll_lag2 <= clf_pkg::RST_FLL_LAG2;
            r_coefs.fll_lag1 <= clf_pkg::RST_FLL_LAG1;
            r_coefs.fll_now  <= clf_pkg::RST_FLL_NOW;
            r_coefs.pll_lag1 <= clf_pkg::RST_PLL_LAG1;
            r_coefs.pll_now  <= clf_pkg::RST_PLL_NOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                clf_pkg::CFG_FLL_LAG2: r_coefs.fll_lag2 <= $signed(i_cfg_data);
                clf_pkg::CFG_FLL_LAG1: r_coefs.fll_lag1 <= $signed(i_cfg_data);
                clf_pkg::CFG_FLL_NOW:  r_coefs.fll_now  <= $signed(i_cfg_data);
                clf_pkg::CFG_PLL_LAG1: r_coefs.pll_lag1 <= $signed(i_cfg_data);
                clf_pkg::CFG_PLL_NOW:  r_coefs.pll_now  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    clf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_sample_value (i_sample_value),
        .o_head         (w_head),
        .i_head_pop     (w_head_pop)
    );

    clf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_head_pop  (w_head_pop),
        .i_coefs     (r_coefs),
        .o_res_valid (w_res_valid),
        .o_res_value (w_res_value),
        .i_res_ready (w_slot_ready)
    );

    assign w_slot_ready = !r_ov || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_res_valid && w_slot_ready) begin
            r_ov <= 1'b1;
        end else if (pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_slot_ready) begin
            r_out <= w_res_value;
        end
    end

    assign empty           = !r_ov;
    assign o_carrier_error = r_out;

endmodule

// File: hw/rtl/clf_front.sv
`timescale 1ns / 1ps

module clf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_kind,
    input  logic signed [clf_pkg::DW-1:0] i_sample_value,
    output clf_pkg::t_head                o_head,
    input  logic                          i_head_pop
);

    clf_pkg::t_item        r_mem [clf_pkg::QDEPTH];
    logic [clf_pkg::QAW-1:0] r_wr_ptr;
    logic [clf_pkg::QAW-1:0] r_rd_ptr;
    logic [clf_pkg::QAW:0]   r_count;
    logic                  w_accept;
    logic                  w_keep;
    logic                  w_pop;
    clf_pkg::t_item        w_item;

    always_comb begin
        w_keep = 1'b1;
        w_item.value = i_sample_value;
        unique case (i_kind)
            clf_pkg::KIND_START: w_item.op = clf_pkg::OP_START;
            clf_pkg::KIND_FLL:   w_item.op = clf_pkg::OP_FLL;
            clf_pkg::KIND_PLL:   w_item.op = clf_pkg::OP_PLL;
            default: begin
                w_item.op = clf_pkg::OP_START;
                w_keep    = 1'b0;
            end
        endcase
    end

    assign full     = (r_count == (clf_pkg::QAW+1)'(clf_pkg::QDEPTH));
    assign w_accept = push && !full && w_keep;
    assign w_pop    = i_head_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_accept) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_accept && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_accept && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

// File: hw/rtl/clf_back.sv
`timescale 1ns / 1ps

module clf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clf_pkg::t_head                i_head,
    output logic                          o_head_pop,
    input  clf_pkg::t_coefs               i_coefs,
    output logic                          o_res_valid,
    output logic signed [clf_pkg::DW-1:0] o_res_value,
    input  logic                          i_res_ready
);

    clf_pkg::t_state r_state;
    clf_pkg::t_state n_state;
    clf_pkg::t_op    r_op;
    logic [1:0]      r_tap;
    logic            r_pv;
    logic signed [clf_pkg::DW-1:0] r_x;
    logic signed [clf_pkg::DW-1:0] r_fo1, r_fo2, r_fd1, r_fd2, r_po1, r_pd1;
    logic signed [55:0] r_ph;
    logic signed [56:0] r_pl;
    logic signed [clf_pkg::AW-1:0] r_acc;

    logic signed [clf_pkg::CW-1:0] w_coef;
    logic signed [clf_pkg::DW-1:0] w_opx;
    logic signed [23:0] w_chi;
    logic signed [24:0] w_clo;
    logic signed [55:0] w_ph;
    logic signed [56:0] w_pl;
    logic signed [clf_pkg::AW-1:0] w_contrib;
    logic signed [33:0] w_base;
    logic signed [37:0] w_r;
    logic signed [clf_pkg::DW-1:0] w_y;
    logic            w_last;
    logic            w_load;
    logic            w_seed;
    logic            w_done;

    // select tap operands
    always_comb begin
        w_coef = i_coefs.pll_now;
        w_opx  = r_x;
        case (r_op)
            clf_pkg::OP_FLL: begin
                case (r_tap)
                    2'd0: begin
                        w_coef = i_coefs.fll_lag2;
                        w_opx  = r_fd2;
                    end
                    2'd1: begin
                        w_coef = i_coefs.fll_lag1;
                        w_opx  = r_fd1;
                    end
                    default: begin
                        w_coef = i_coefs.fll_now;
                        w_opx  = r_x;
                    end
                endcase
            end
            default: begin
                if (r_tap == 2'd0) begin
                    w_coef = i_coefs.pll_lag1;
                    w_opx  = r_pd1;
                end
            end
        endcase
    end

    assign w_last = (r_op == clf_pkg::OP_FLL) ? (r_tap == 2'd2) : (r_tap == 2'd1);
    assign w_chi  = w_coef[47:24];
    assign w_clo  = $signed({1'b0, w_coef[23:0]});
    assign w_ph   = w_chi * w_opx;
    assign w_pl   = w_clo * w_opx;
    assign w_contrib = $signed({{4{r_ph[55]}}, r_ph, 24'b0})
                     + $signed({{27{r_pl[56]}}, r_pl});

    always_comb begin
        if (i_head.item.op == clf_pkg::OP_FLL) begin
            w_base = $signed({r_fo1[31], r_fo1, 1'b0}) - $signed({{2{r_fo2[31]}}, r_fo2});
        end else begin
            w_base = $signed({{2{r_po1[31]}}, r_po1});
        end
    end

    assign w_r = r_acc[clf_pkg::AW-1:46];
    always_comb begin
        if (w_r[37:31] == {7{w_r[31]}}) begin
            w_y = w_r[31:0];
        end else if (w_r[37]) begin
            w_y = $signed({1'b1, {(clf_pkg::DW-1){1'b0}}});
        end else begin
            w_y = $signed({1'b0, {(clf_pkg::DW-1){1'b1}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_head_pop  = 1'b0;
        o_res_valid = 1'b0;
        w_load      = 1'b0;
        w_seed      = 1'b0;
        w_done      = 1'b0;
        unique case (r_state)
            clf_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    o_head_pop = 1'b1;
                    if (i_head.item.op == clf_pkg::OP_START) begin
                        w_seed = 1'b1;
                    end else begin
                        w_load  = 1'b1;
                        n_state = clf_pkg::ST_MUL;
                    end
                end
            end
            clf_pkg::ST_MUL: begin
                if (w_last) begin
                    n_state = clf_pkg::ST_DRAIN;
                end
            end
            clf_pkg::ST_DRAIN: begin
                n_state = clf_pkg::ST_FIN;
            end
            clf_pkg::ST_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    w_done  = 1'b1;
                    n_state = clf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = clf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res_value = w_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_tap <= '0;
            r_op  <= clf_pkg::OP_FLL;
            r_fo1 <= '0;
            r_fo2 <= '0;
            r_fd1 <= '0;
            r_fd2 <= '0;
            r_po1 <= '0;
            r_pd1 <= '0;
        end else begin
            r_pv <= (r_state == clf_pkg::ST_MUL);
            if (w_load) begin
                r_op  <= i_head.item.op;
                r_tap <= '0;
            end else if (r_state == clf_pkg::ST_MUL) begin
                r_tap <= r_tap + 1'b1;
            end
            if (w_seed) begin
                r_fo1 <= i_head.item.value;
                r_fo2 <= i_head.item.value;
                r_fd1 <= '0;
                r_fd2 <= '0;
                r_po1 <= '0;
                r_pd1 <= '0;
            end else if (w_done) begin
                if (r_op == clf_pkg::OP_FLL) begin
                    r_fo2 <= r_fo1;
                    r_fo1 <= w_y;
                    r_fd2 <= r_fd1;
                    r_fd1 <= r_x;
                end else begin
                    r_po1 <= w_y;
                    r_pd1 <= r_x;
                end
            end
        end
    end

    // seed with rounding half, accumulate partial products
    always_ff @(posedge i_clk) begin
        r_ph <= w_ph;
        r_pl <= w_pl;
        if (w_load) begin
            r_x   <= i_head.item.value;
            r_acc <= $signed({{4{w_base[33]}}, w_base, 1'b1, 45'b0});
        end else if (r_pv) begin
            r_acc <= r_acc + w_contrib;
        end
    end

    a_pll_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clf_pkg::ST_MUL && r_op == clf_pkg::OP_PLL) |-> (r_tap <= 2'd1))
        else $error("pll tap index overrun");

    a_fin_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clf_pkg::ST_FIN && i_res_ready) |=> (r_state == clf_pkg::ST_IDLE))
        else $error("result taken but sequencer not idle");

    a_pv_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == clf_pkg::ST_MUL || r_state == clf_pkg::ST_DRAIN))
        else $error("product valid outside accumulate window");

    a_drain_has_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clf_pkg::ST_DRAIN) |-> r_pv)
        else $error("drain without pending product");

endmodule
